// ----- rtl/pssrc_pkg.sv -----
// Shared widths, codes and reset values for the PWM soft-start ramp controller.
`timescale 1ns / 1ps

package pssrc_pkg;

  localparam int TICK_MS_DEF = 10;

  localparam int MS_W    = 16;
  localparam int SLOPE_W = 5;
  localparam int PHASE_W = 2;

  // stream packing
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_DUTY_LSB  = 0;
  localparam int OUT_EN_BIT    = 16;
  localparam int OUT_PHASE_LSB = 17;
  localparam int OUT_SET_BIT   = 19;
  localparam int OUT_SLOPE_LSB = 20;
  localparam int OUT_USED_W    = 25;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_START   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_STOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOPE    = 3'd6;

  localparam logic [MS_W-1:0]    RST_PWM_PERIOD = 16'd1999;
  localparam logic [MS_W-1:0]    RST_LONG_PRESS = 16'd3000;
  localparam logic [MS_W-1:0]    RST_SHORT_MIN  = 16'd100;
  localparam logic [MS_W-1:0]    RST_SHORT_MAX  = 16'd2000;
  localparam logic [MS_W-1:0]    RST_TRIG_START = 16'd100;
  localparam logic [MS_W-1:0]    RST_TRIG_STOP  = 16'd500;
  localparam logic [SLOPE_W-1:0] RST_MAX_SLOPE  = 5'd21;
  localparam logic [SLOPE_W-1:0] RST_SLOPE      = 5'd8;

  // ramp phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_INIT   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_OUTPUT = 2'd2;
  localparam logic [PHASE_W-1:0] PH_END    = 2'd3;

  // compare = floor(P*(t*99 + S*1000) / (S*100000))
  localparam int ACC_W = 23;            // t*99 + S*1000
  localparam int NUM_W = ACC_W + MS_W;  // times P
  localparam int DEN_W = 22;            // S*100000
  localparam int QUO_W = 23;            // quotient bound for 39-bit numerator
  localparam logic [ACC_W-1:0] T_GAIN    = 23'd99;
  localparam logic [ACC_W-1:0] S_GAIN    = 23'd1000;
  localparam logic [DEN_W-1:0] DEN_GAIN  = 22'd100000;
  localparam logic [MS_W-1:0]  MS_PER_S  = 16'd1000;

endpackage

// ----- rtl/pwm_soft_start_ramp_controller_top.sv -----
// Top level of the PWM soft-start ramp controller: tick handling and compare divider.
`timescale 1ns / 1ps

// PWM soft-start ramp controller.
// Slave stream: one request per timer tick carrying the sampled trigger and key
// levels. Master stream: one request per tick with the compare value, enable,
// phase, setting flag and slope after that tick's update.
// Configuration: cfg_we/cfg_index/cfg_data write a register on the clock edge;
// the user must do so only while the block is idle; the block does not enforce it.
// Sequencing: a tick that does not advance the ramp goes straight to the output
// step. A ramp tick first recomputes the compare value through a
// multiply step, a 39-bit product, and a restoring divider that retires one
// quotient bit per cycle on a single shared subtractor, then saturates it.
// Throughput: one tick at a time; s_tready is high only while the sequencer
// waits for a tick, also while a finished result still sits in the output
// register. When m_tready stays low the sequencer holds in its output step
// and the result register keeps its contents.
// Reset (rst, synchronous): configuration back to defaults, phase idle, slope
// 8, all counters, compare and enable cleared, output register empty.
module pwm_soft_start_ramp_controller_top #(
  parameter int TICK_MS = pssrc_pkg::TICK_MS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pssrc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] trigger_level, [1] key_pressed
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pssrc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [15:0] duty_compare,
                                                         // [16] output_enabled, [18:17] phase,
                                                         // [19] in_setting,
                                                         // [24:20] slope_seconds_out
  input  logic                                cfg_we,
  input  logic [pssrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pssrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pssrc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic [MS_W:0] TICK_INC = (MS_W + 1)'(TICK_MS);

  // configuration
  logic [MS_W-1:0]    pwm_period;
  logic [MS_W-1:0]    long_press_ms;
  logic [MS_W-1:0]    short_press_min_ms;
  logic [MS_W-1:0]    short_press_max_ms;
  logic [MS_W-1:0]    trigger_start_ms;
  logic [MS_W-1:0]    trigger_stop_ms;
  logic [SLOPE_W-1:0] max_slope_seconds;

  // controller state
  logic [2:0]         state;
  logic [PHASE_W-1:0] phase_reg,       phase_next;
  logic               setting_flag,    setting_next;
  logic [SLOPE_W-1:0] slope_seconds,   slope_next;
  logic [MS_W-1:0]    ramp_elapsed_ms, ramp_next;
  logic [MS_W-1:0]    key_hold_ms,     key_hold_next;
  logic [MS_W-1:0]    trigger_high_ms, trigger_high_next;
  logic [MS_W-1:0]    trigger_low_ms,  trigger_low_next;
  logic [MS_W-1:0]    compare_reg;
  logic               enable_reg,      enable_next;
  logic               need_cmp;

  // divider datapath
  logic [ACC_W-1:0] acc;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] qsh;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] prod;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [SLOPE_W-1:0] slope_div;

  logic trig, key, accept;
  logic [SLOPE_W:0] slope_inc;

  function automatic logic [MS_W-1:0] sat_add(input logic [MS_W-1:0] a);
    logic [MS_W:0] s;
    s = {1'b0, a} + TICK_INC;
    return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
  endfunction

  assign trig     = s_tdata[0];
  assign key      = s_tdata[1];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // one tick of the key handler and phase machine
  always_comb begin
    phase_next        = phase_reg;
    setting_next      = setting_flag;
    slope_next        = slope_seconds;
    ramp_next         = ramp_elapsed_ms;
    key_hold_next     = key_hold_ms;
    trigger_high_next = trigger_high_ms;
    trigger_low_next  = trigger_low_ms;
    enable_next       = enable_reg;
    need_cmp          = 1'b0;
    slope_inc         = {1'b0, slope_seconds} + (SLOPE_W + 1)'(1);
    if (key) begin
      key_hold_next = sat_add(key_hold_ms);
    end else begin
      if (key_hold_ms != '0) begin
        key_hold_next = '0;
        if (!setting_flag) begin
          if (key_hold_ms >= long_press_ms) begin
            setting_next = 1'b1;
            slope_next   = SLOPE_W'(1);
            enable_next  = 1'b0;
          end
        end else if (key_hold_ms >= long_press_ms) begin
          setting_next = 1'b0;
          enable_next  = 1'b1;
        end else if (key_hold_ms >= short_press_min_ms &&
                     key_hold_ms <= short_press_max_ms) begin
          slope_next = (slope_inc > {1'b0, max_slope_seconds}) ? SLOPE_W'(1)
                                                               : slope_inc[SLOPE_W-1:0];
        end
      end
      if (!setting_next) begin
        unique case (phase_reg)
          PH_IDLE: begin
            if (trig) begin
              trigger_high_next = sat_add(trigger_high_ms);
            end else begin
              if (trigger_high_ms >= trigger_start_ms) phase_next = PH_INIT;
              trigger_high_next = '0;
            end
          end
          PH_INIT: begin
            ramp_next        = '0;
            trigger_low_next = '0;
            phase_next       = PH_OUTPUT;
          end
          PH_OUTPUT: begin
            if (!trig) begin
              trigger_low_next = sat_add(trigger_low_ms);
            end else begin
              if (trigger_low_ms >= trigger_stop_ms) phase_next = PH_END;
              trigger_low_next = '0;
              ramp_next        = sat_add(ramp_elapsed_ms);
              enable_next      = 1'b1;
              need_cmp         = 1'b1;
              if (ramp_next >= MS_W'(MS_W'(slope_next) * MS_PER_S)) phase_next = PH_END;
            end
          end
          PH_END: begin
            enable_next       = 1'b0;
            ramp_next         = '0;
            trigger_high_next = '0;
            phase_next        = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // divider operand, product and shared subtractor of the restoring divider
  assign slope_div = (slope_seconds == '0) ? SLOPE_W'(1) : slope_seconds;
  assign prod  = NUM_W'(acc) * NUM_W'(pwm_period);
  assign trial = {rem, qsh[QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period         <= RST_PWM_PERIOD;
      long_press_ms      <= RST_LONG_PRESS;
      short_press_min_ms <= RST_SHORT_MIN;
      short_press_max_ms <= RST_SHORT_MAX;
      trigger_start_ms   <= RST_TRIG_START;
      trigger_stop_ms    <= RST_TRIG_STOP;
      max_slope_seconds  <= RST_MAX_SLOPE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PWM_PERIOD: pwm_period         <= cfg_data;
        REG_LONG_PRESS: long_press_ms      <= cfg_data;
        REG_SHORT_MIN:  short_press_min_ms <= cfg_data;
        REG_SHORT_MAX:  short_press_max_ms <= cfg_data;
        REG_TRIG_START: trigger_start_ms   <= cfg_data;
        REG_TRIG_STOP:  trigger_stop_ms    <= cfg_data;
        REG_MAX_SLOPE:  max_slope_seconds  <= cfg_data[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase_reg       <= PH_IDLE;
      setting_flag    <= 1'b0;
      slope_seconds   <= RST_SLOPE;
      ramp_elapsed_ms <= '0;
      key_hold_ms     <= '0;
      trigger_high_ms <= '0;
      trigger_low_ms  <= '0;
      compare_reg     <= '0;
      enable_reg      <= 1'b0;
      m_tvalid        <= 1'b0;
      cnt             <= '0;
    end else begin
      // the output step reloads the valid flag itself
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            phase_reg       <= phase_next;
            setting_flag    <= setting_next;
            slope_seconds   <= slope_next;
            ramp_elapsed_ms <= ramp_next;
            key_hold_ms     <= key_hold_next;
            trigger_high_ms <= trigger_high_next;
            trigger_low_ms  <= trigger_low_next;
            enable_reg      <= enable_next;
            state           <= need_cmp ? ST_MUL1 : ST_OUT;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: begin
          cnt   <= CNT_W'(QUO_W);
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state <= ST_SAT;
        end
        ST_SAT: begin
          compare_reg <= (|qsh[QUO_W-1:MS_W]) ? {MS_W{1'b1}} : qsh[MS_W-1:0];
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider operands and result register; no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MUL1: begin
        acc <= ACC_W'(ramp_elapsed_ms) * T_GAIN + ACC_W'(slope_div) * S_GAIN;
        den <= DEN_W'(slope_div) * DEN_GAIN;
      end
      ST_MUL2: begin
        // quotient stays below 2^23, so the top bits are already below den
        rem <= DEN_W'(prod[NUM_W-1:QUO_W]);
        qsh <= prod[QUO_W-1:0];
      end
      ST_DIV: begin
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qsh <= {qsh[QUO_W-2:0], ge};
      end
      default: ;
    endcase
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, slope_seconds, setting_flag,
                  phase_reg, enable_reg, compare_reg};
    end
  end

endmodule

// ----- rtl/pssrc_checker.sv -----
// Port-level assertions for the PWM soft-start ramp controller, bound to the top level.
`timescale 1ns / 1ps

module pssrc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [pssrc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import pssrc_pkg::*;

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // one tick at a time: the sequencer leaves its wait state after a request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second tick taken while one is in work");

  // entering setting mode forces the output off, and nothing turns it on there
  a_setting_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_SET_BIT] |-> !m_tdata[OUT_EN_BIT])
    else $error("output enabled in setting mode");

  // slope never reaches zero; padding stays clear
  a_slope_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_SLOPE_LSB +: SLOPE_W] != '0 &&
                 m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
    else $error("bad slope or padding in result");

endmodule

bind pwm_soft_start_ramp_controller_top pssrc_checker u_pssrc_checker (.*);

// ----- tb/sv/pssrc_ramp_checker.sv -----
// Checker for the PWM soft-start ramp controller: per-tick status predictor and comparison.
`timescale 1ns / 1ps

module pssrc_ramp_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [pssrc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] trigger_level, [1] key_pressed
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [pssrc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [15:0] duty_compare,
                                                       // [16] output_enabled,
                                                       // [18:17] phase, [19] in_setting,
                                                       // [24:20] slope_seconds_out
  input  logic                              cfg_we,
  input  logic [pssrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pssrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                fail_count,
  output int                                ticks_in_flight
);
  import pssrc_pkg::*;

  localparam int TICK = TICK_MS_DEF;

  typedef struct packed {
    logic [MS_W-1:0]    duty;
    logic               en;
    logic [PHASE_W-1:0] phase;
    logic               setting;
    logic [SLOPE_W-1:0] slope;
  } tick_status_t;

  // register copies
  logic [MS_W-1:0]    period_cfg, long_cfg, short_min_cfg, short_max_cfg;
  logic [MS_W-1:0]    start_cfg, stop_cfg;
  logic [SLOPE_W-1:0] slope_max_cfg;

  // controller state copy
  logic [PHASE_W-1:0] ramp_phase;
  logic               setting_mode;
  logic [SLOPE_W-1:0] slope_s;
  logic [MS_W-1:0]    ramp_ms, key_ms, high_ms, low_ms, duty;
  logic               enable;

  tick_status_t expected_status[$];
  tick_status_t got, want, next_status;
  logic               trig_bit, key_bit;
  logic [MS_W-1:0]    held_ms;
  logic [SLOPE_W:0]   slope_up;
  logic [63:0]        sd, num, quo;
  int                 mismatches = 0;

  function automatic logic [MS_W-1:0] add_tick(input logic [MS_W-1:0] v);
    logic [MS_W:0] s;
    s = {1'b0, v} + (MS_W + 1)'(TICK);
    return s[MS_W] ? '1 : s[MS_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      period_cfg    = RST_PWM_PERIOD;
      long_cfg      = RST_LONG_PRESS;
      short_min_cfg = RST_SHORT_MIN;
      short_max_cfg = RST_SHORT_MAX;
      start_cfg     = RST_TRIG_START;
      stop_cfg      = RST_TRIG_STOP;
      slope_max_cfg = RST_MAX_SLOPE;
      ramp_phase    = PH_IDLE;
      setting_mode  = 1'b0;
      slope_s       = RST_SLOPE;
      ramp_ms       = '0;
      key_ms        = '0;
      high_ms       = '0;
      low_ms        = '0;
      duty          = '0;
      enable        = 1'b0;
      expected_status.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PWM_PERIOD: period_cfg    = cfg_data;
          REG_LONG_PRESS: long_cfg      = cfg_data;
          REG_SHORT_MIN:  short_min_cfg = cfg_data;
          REG_SHORT_MAX:  short_max_cfg = cfg_data;
          REG_TRIG_START: start_cfg     = cfg_data;
          REG_TRIG_STOP:  stop_cfg      = cfg_data;
          REG_MAX_SLOPE:  slope_max_cfg = cfg_data[SLOPE_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        got.duty    = m_tdata[OUT_DUTY_LSB +: MS_W];
        got.en      = m_tdata[OUT_EN_BIT];
        got.phase   = m_tdata[OUT_PHASE_LSB +: PHASE_W];
        got.setting = m_tdata[OUT_SET_BIT];
        got.slope   = m_tdata[OUT_SLOPE_LSB +: SLOPE_W];
        if (expected_status.size() == 0) begin
          $error("result request with no tick pending: %h", m_tdata[OUT_USED_W-1:0]);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty_compare: expected %0d, actual %0d", want.duty, got.duty);
            mismatches++;
          end
          if (got.en !== want.en) begin
            $error("output_enabled: expected %0d, actual %0d", want.en, got.en);
            mismatches++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, got.phase);
            mismatches++;
          end
          if (got.setting !== want.setting) begin
            $error("in_setting: expected %0d, actual %0d", want.setting, got.setting);
            mismatches++;
          end
          if (got.slope !== want.slope) begin
            $error("slope_seconds_out: expected %0d, actual %0d", want.slope, got.slope);
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        trig_bit = s_tdata[0];
        key_bit  = s_tdata[1];
        if (key_bit) begin
          // key held: everything else frozen
          key_ms = add_tick(key_ms);
        end else begin
          if (key_ms != '0) begin
            held_ms = key_ms;
            key_ms  = '0;
            if (!setting_mode) begin
              if (held_ms >= long_cfg) begin
                setting_mode = 1'b1;
                slope_s      = SLOPE_W'(1);
                enable       = 1'b0;
              end
            end else if (held_ms >= long_cfg) begin
              setting_mode = 1'b0;
              enable       = 1'b1;
            end else if (held_ms >= short_min_cfg && held_ms <= short_max_cfg) begin
              slope_up = slope_s + 1'b1;
              slope_s  = (slope_up > slope_max_cfg) ? SLOPE_W'(1) : slope_up[SLOPE_W-1:0];
            end
          end
          if (!setting_mode) begin
            case (ramp_phase)
              PH_IDLE: begin
                if (trig_bit) begin
                  high_ms = add_tick(high_ms);
                end else begin
                  if (high_ms >= start_cfg) ramp_phase = PH_INIT;
                  high_ms = '0;
                end
              end
              PH_INIT: begin
                ramp_ms    = '0;
                low_ms     = '0;
                ramp_phase = PH_OUTPUT;
              end
              PH_OUTPUT: begin
                if (!trig_bit) begin
                  low_ms = add_tick(low_ms);
                end else begin
                  if (low_ms >= stop_cfg) ramp_phase = PH_END;
                  low_ms  = '0;
                  ramp_ms = add_tick(ramp_ms);
                  // floor(P*(t*99 + S*1000) / (S*100000)), saturated
                  sd = 64'(slope_s);
                  if (sd == 0) sd = 1;
                  num  = ramp_ms * period_cfg * 99 + period_cfg * sd * 1000;
                  quo  = num / (sd * 100000);
                  duty = (quo > 64'hFFFF) ? '1 : quo[MS_W-1:0];
                  enable = 1'b1;
                  if (ramp_ms >= slope_s * 1000) ramp_phase = PH_END;
                end
              end
              PH_END: begin
                enable     = 1'b0;
                ramp_ms    = '0;
                high_ms    = '0;
                ramp_phase = PH_IDLE;
              end
              default: ;
            endcase
          end
        end
        next_status.duty    = duty;
        next_status.en      = enable;
        next_status.phase   = ramp_phase;
        next_status.setting = setting_mode;
        next_status.slope   = slope_s;
        expected_status.push_back(next_status);
      end
    end
    fail_count      <= mismatches;
    ticks_in_flight <= expected_status.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the PWM soft-start ramp controller: clock, reset, tick stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import pssrc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int TICK        = TICK_MS_DEF;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [0] trigger_level, [1] key_pressed
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [15:0] duty_compare, [16] output_enabled,
                                            // [18:17] phase, [19] in_setting,
                                            // [24:20] slope_seconds_out
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int   fail_count;
  int   ticks_in_flight;
  logic gaps_on    = 1'b0;
  logic stalls_on  = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   phase_ticks  = 0;
  // thresholds in ticks, for shaping the stimulus
  int   long_ticks, short_lo_ticks, short_hi_ticks, start_ticks, stop_ticks;

  initial forever #1 clk = ~clk;

  pwm_soft_start_ramp_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pssrc_ramp_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .ticks_in_flight (ticks_in_flight)
  );

  // receiver back-pressure in random bursts while stalls are on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_tick(input logic trig, input logic key);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-2){1'b0}}, key, trig};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    phase_ticks++;
  endtask

  task automatic drive_run(input logic trig, input logic key, input int n);
    repeat (n) send_tick(trig, key);
  endtask

  // key held for n ticks, then released; trigger level is noise meanwhile
  task automatic press_key(input int n);
    repeat (n) send_tick($urandom_range(0, 1) == 1, 1'b1);
    send_tick($urandom_range(0, 1) == 1, 1'b0);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ticks_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] period, input logic [15:0] long_ms,
                              input logic [15:0] short_lo, input logic [15:0] short_hi,
                              input logic [15:0] start_ms, input logic [15:0] stop_ms,
                              input logic [15:0] slope_top);
    drain_results();
    write_reg(REG_PWM_PERIOD, period);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_SHORT_MIN, short_lo);
    write_reg(REG_SHORT_MAX, short_hi);
    write_reg(REG_TRIG_START, start_ms);
    write_reg(REG_TRIG_STOP, stop_ms);
    write_reg(REG_MAX_SLOPE, slope_top);
    cfg_we <= 1'b0;
    long_ticks     = long_ms / TICK;
    short_lo_ticks = short_lo / TICK;
    short_hi_ticks = short_hi / TICK;
    start_ticks    = start_ms / TICK;
    stop_ticks     = stop_ms / TICK;
  endtask

  task automatic apply_random_config();
    int lo;
    lo = $urandom_range(0, 30);
    apply_config(16'($urandom_range(1, 65535)), 16'($urandom_range(10, 80)), 16'(lo),
                 16'($urandom_range(lo, 60)), 16'($urandom_range(0, 50)),
                 16'($urandom_range(0, 60)), 16'($urandom_range(1, 6)));
  endtask

  function automatic int fit_ticks(input int n);
    return (n < 1) ? 1 : (n > 700) ? 700 : n;
  endfunction

  // mostly well-formed pulses, ramps, gaps and presses sized to the thresholds
  task automatic random_phase(input int count, input bit with_idling);
    int n;
    phase_ticks = 0;
    while (phase_ticks < count) begin
      gaps_on   = with_idling && ($urandom_range(0, 3) != 0);
      stalls_on <= with_idling && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = fit_ticks(start_ticks - 1 + int'($urandom_range(0, 3)));
          drive_run(1'b1, 1'b0, n);
          send_tick(1'b0, 1'b0);
        end
        3, 4: begin
          repeat ($urandom_range(5, 40)) send_tick($urandom_range(0, 7) != 0, 1'b0);
        end
        5: begin
          n = fit_ticks(stop_ticks - 1 + int'($urandom_range(0, 2)));
          drive_run(1'b0, 1'b0, n);
          send_tick(1'b1, 1'b0);
        end
        6, 7: begin
          case ($urandom_range(0, 2))
            0:       n = $urandom_range(short_lo_ticks, short_hi_ticks + 1);
            1:       n = long_ticks - 1 + int'($urandom_range(0, 2));
            default: n = $urandom_range(1, 12);
          endcase
          press_key(fit_ticks(n));
        end
        default: begin
          repeat ($urandom_range(1, 8))
            send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;
    stalls_on <= 1'b1;

    // short thresholds so every path is a few ticks long
    apply_config(16'hFFFF, 16'd30, 16'd10, 16'd20, 16'd20, 16'd30, 16'd3);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);        // key held: trigger ignored
    send_tick(1'b0, 1'b0);        // too short to count outside setting mode
    drive_run(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b0);        // pulse long enough: init
    send_tick(1'b1, 1'b0);        // init to output
    drive_run(1'b1, 1'b0, 2);
    drive_run(1'b0, 1'b0, 3);     // trigger away for the stop time
    send_tick(1'b1, 1'b0);        // returns: last ramp step, then end
    send_tick(1'b0, 1'b0);        // end to idle, output off
    press_key(3);                 // enter setting, slope 1
    press_key(1);
    press_key(2);
    press_key(1);                 // wraps back to 1
    press_key(3);                 // leave setting, output forced on

    // slope cut to 1 in the middle of a long ramp: compare overflows
    press_key(3);
    press_key(1);
    press_key(3);
    drive_run(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    drive_run(1'b1, 1'b0, 110);
    press_key(3);
    press_key(3);
    drive_run(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b0);

    apply_random_config();
    random_phase(80, 1'b1);
    apply_random_config();
    random_phase(80, 1'b1);
    // zero start and stop times, slope maximum of zero, period of one
    apply_config(16'd1, 16'd40, 16'd0, 16'd30, 16'd0, 16'd0, 16'd0);
    random_phase(50, 1'b1);
    apply_config(16'hFFFF, 16'd10, 16'd0, 16'd0, 16'd10, 16'hFFFF, 16'd31);
    random_phase(60, 1'b1);
    apply_config(RST_PWM_PERIOD, RST_LONG_PRESS, RST_SHORT_MIN, RST_SHORT_MAX,
                 RST_TRIG_START, RST_TRIG_STOP, 16'(RST_MAX_SLOPE));
    random_phase(60, 1'b1);

    apply_random_config();
    random_phase(60, 1'b0);

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
